>>> rtl/core/lcts_pkg.sv
// shared types, codes and font table of the led cube text scroller
`timescale 1ns / 1ps

package lcts_pkg;

  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_ROWS = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [6:0] FONT_FIRST = 7'h20;
  localparam logic [6:0] END_CODE = 7'h00;
  localparam logic [2:0] GLYPH_COLUMNS = 3'd6;
  localparam logic [7:0] VERT_MASK_TOP = 8'h80;
  localparam logic [7:0] HORZ_MASK = 8'h1F;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_VERT = 2'd1,
    CMD_HORZ = 2'd2
  } command_t;

  typedef struct packed {
    command_t   command;
    logic [6:0] char_code;
    logic [2:0] pos_x;
    logic [2:0] pos_y;
    logic [2:0] pos_z;
  } item_t;

  typedef struct packed {
    logic       write_valid;
    logic [5:0] frame_address;
    logic [7:0] write_mask;
    logic [7:0] write_data;
    logic       need_char;
    logic       text_done;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,
    JOB_VERT   = 2'd1,
    JOB_HORZ   = 2'd2
  } job_kind_t;

  // one classified item on its way to the back end
  typedef struct packed {
    job_kind_t  kind;
    logic [5:0] addr;
    logic [7:0] mask;
    logic [7:0] data;   // vertical: one bit per row, horizontal: write data
    logic       need;
    logic       done;
  } job_t;

  // one byte per row, row 0 in the top byte, low five bits used
  localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h0404040004, 40'h0A0A000000, 40'h0A1F0A1F0A,
    40'h0F140E051E, 40'h1102040811, 40'h08140D120D, 40'h0404000000,
    40'h0204040402, 40'h0804040408, 40'h150E1F0E15, 40'h04041F0404,
    40'h0000000408, 40'h00001F0000, 40'h0000000008, 40'h0102040810,
    40'h0E1315190E, 40'h040C04040E, 40'h0E11020C1F, 40'h0E1106110E,
    40'h040C1E0404, 40'h1E101E011E, 40'h0E101E110E, 40'h1F02040810,
    40'h0E110E110E, 40'h0E110E010E, 40'h0404000404, 40'h0404000408,
    40'h0408100804, 40'h001F001F00, 40'h0402010204, 40'h0E11060004,
    40'h0E1315170D, 40'h040A1F1111, 40'h1E111E111E, 40'h0E1110110E,
    40'h1E1111111E, 40'h1F101C101F, 40'h1F101C1010, 40'h0E1017120E,
    40'h11111F1111, 40'h0E0404040E, 40'h010101110E, 40'h11121C1211,
    40'h101010101F, 40'h111B151111, 40'h1119151311, 40'h0E1111110E,
    40'h1E111E1010, 40'h0E1115130F, 40'h1E111E1211, 40'h0F100E011E,
    40'h1F04040404, 40'h111111110E, 40'h1111110A04, 40'h111111150A,
    40'h110A040A11, 40'h110A040404, 40'h1F0204081F, 40'h0E0808080E,
    40'h1008040201, 40'h0E0202020E, 40'h040A110000, 40'h000000001F,
    40'h1010000000, 40'h040A1F1111, 40'h1E111E111E, 40'h0E1110110E,
    40'h1E1111111E, 40'h1F101C101F, 40'h1F101C1010, 40'h0E1017120E,
    40'h11111F1111, 40'h0E0404040E, 40'h010101110E, 40'h11121C1211,
    40'h101010101F, 40'h111B151111, 40'h1119151311, 40'h0E1111110E,
    40'h1E111E1010, 40'h0E1115130F, 40'h1E111E1211, 40'h0F100E011E,
    40'h1F04040404, 40'h111111110E, 40'h1111110A04, 40'h111111150A,
    40'h110A040A11, 40'h110A040404, 40'h1F0204081F, 40'h0608180806,
    40'h0404040404, 40'h0C0203020C, 40'h140A000000, 40'h1F1111111F
  };

  // control codes and codes past the font show as space
  function automatic logic [39:0] glyph_of(input logic [6:0] code);
    logic [6:0] idx;
    idx = code - FONT_FIRST;
    if (code < FONT_FIRST || idx >= 7'(GLYPH_COUNT)) begin
      return FONT_ROM[0];
    end
    return FONT_ROM[idx];
  endfunction

endpackage

>>> rtl/core/lcts_front.sv
// front end: takes items, keeps the glyph state and classifies each item into a job
`timescale 1ns / 1ps

module lcts_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            full,
  input  lcts_pkg::item_t item,
  output logic            job_push,
  output lcts_pkg::job_t  job
);

  logic [5:0] rows [lcts_pkg::GLYPH_ROWS];
  logic [5:0] rows_next [lcts_pkg::GLYPH_ROWS];
  logic [2:0] columns_left;
  logic [2:0] columns_left_next;
  logic       text_finished;
  logic       text_finished_next;
  logic [2:0] columns_used;
  logic [39:0] glyph;
  logic [1:0] shift;
  logic [7:0] hmask;

  assign job_push = push && !full;
  assign glyph = lcts_pkg::glyph_of(item.char_code);
  // column count holds at zero
  assign columns_used = (columns_left != 3'd0) ? columns_left - 3'd1 : 3'd0;
  assign shift = 2'd3 - item.pos_x[1:0];
  assign hmask = lcts_pkg::HORZ_MASK << shift;

  always_comb begin
    rows_next = rows;
    columns_left_next = columns_left;
    text_finished_next = text_finished;
    job = '0;
    job.kind = lcts_pkg::JOB_STATUS;
    job.done = text_finished;
    case (item.command)
      lcts_pkg::CMD_LOAD: begin
        if (item.char_code == lcts_pkg::END_CODE) begin
          text_finished_next = 1'b1;
          job.done = 1'b1;
        end else begin
          for (int k = 0; k < lcts_pkg::GLYPH_ROWS; k++) begin
            rows_next[k] = {1'b0, glyph[32 - 8 * k +: 5]};
          end
          columns_left_next = lcts_pkg::GLYPH_COLUMNS;
          text_finished_next = 1'b0;
          job.done = 1'b0;
        end
      end
      lcts_pkg::CMD_VERT: begin
        if (!text_finished) begin
          job.kind = lcts_pkg::JOB_VERT;
          job.addr = {1'b0, item.pos_y[1:0], item.pos_z};
          job.mask = lcts_pkg::VERT_MASK_TOP >> item.pos_x;
          job.need = (columns_used == 3'd0);
          for (int k = 0; k < lcts_pkg::GLYPH_ROWS; k++) begin
            job.data[k] = rows[k][5];
            rows_next[k] = {rows[k][4:0], 1'b0};
          end
          columns_left_next = columns_used;
        end
      end
      lcts_pkg::CMD_HORZ: begin
        // runs even after the end of text
        job.kind = lcts_pkg::JOB_HORZ;
        job.addr = {item.pos_y, item.pos_z};
        job.mask = hmask;
        job.data = (8'(rows[0]) << shift) & hmask;
        job.need = (columns_used == 3'd0) && !text_finished;
        for (int k = 0; k < lcts_pkg::GLYPH_ROWS - 1; k++) begin
          rows_next[k] = rows[k + 1];
        end
        rows_next[lcts_pkg::GLYPH_ROWS - 1] = '0;
        columns_left_next = columns_used;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < lcts_pkg::GLYPH_ROWS; k++) begin
        rows[k] <= '0;
      end
      columns_left <= '0;
      text_finished <= 1'b1;
    end else if (job_push) begin
      rows <= rows_next;
      columns_left <= columns_left_next;
      text_finished <= text_finished_next;
    end
  end

endmodule

>>> rtl/core/lcts_queue.sv
// short job queue between front and back end
`timescale 1ns / 1ps

module lcts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcts_pkg::job_t push_job,
  input  logic           pop,
  output lcts_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (lcts_pkg::QUEUE_DEPTH > 1) ? $clog2(lcts_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lcts_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lcts_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(lcts_pkg::QUEUE_DEPTH);

  lcts_pkg::job_t   slots [lcts_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == DEPTH_CNT);
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/lcts_back.sv
// back end: expands jobs into frame writes and status results
`timescale 1ns / 1ps

module lcts_back (
  input  logic              clk,
  input  logic              rst,
  input  lcts_pkg::job_t    job,
  input  logic              job_empty,
  output logic              job_pop,
  input  logic              pop,
  output logic              empty,
  output lcts_pkg::result_t result
);

  localparam logic [2:0] LAST_ROW = 3'(lcts_pkg::GLYPH_ROWS - 1);

  logic              out_valid;
  logic [2:0]        row;
  logic [2:0]        row_next;
  logic              emit;
  logic              job_last;
  lcts_pkg::result_t result_next;

  assign empty = !out_valid;
  assign emit = (!out_valid || pop) && !job_empty;
  assign job_last = (job.kind != lcts_pkg::JOB_VERT) || (row == LAST_ROW);
  assign job_pop = emit && job_last;
  assign row_next = job_last ? 3'd0 : row + 3'd1;

  always_comb begin
    result_next = '0;
    result_next.text_done = job.done;
    result_next.last = 1'b1;
    case (job.kind)
      lcts_pkg::JOB_VERT: begin
        result_next.write_valid = 1'b1;
        result_next.frame_address = job.addr + {row, 3'b000};
        result_next.write_mask = job.mask;
        result_next.write_data = job.data[row] ? job.mask : 8'h00;
        result_next.need_char = job_last && job.need;
        result_next.last = job_last;
      end
      lcts_pkg::JOB_HORZ: begin
        result_next.write_valid = 1'b1;
        result_next.frame_address = job.addr;
        result_next.write_mask = job.mask;
        result_next.write_data = job.data;
        result_next.need_char = job.need;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        row <= row_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/led_cube_text_scroller.sv
// top level of the led cube text scroller
// usage:
//   items enter as a queue push: an item is taken at a clock edge with push
//   high and full low. command 0 loads a character glyph (code 0 ends the
//   text), command 1 draws one glyph column as five single-bit frame writes,
//   command 2 draws glyph row 0 as one 5-bit frame write.
//   results leave as a queue pop: while empty is low the oldest result sits
//   on result, and it is taken at an edge with pop high. last marks the
//   final result of each item.
// flow:
//   a job passes the job queue, and results leave from the single result
//   register. load, horizontal draw and unused commands give one result per
//   item, so they stream at one item per cycle while pop is high. a vertical
//   draw gives five results (one status result after the end of text), one
//   per cycle while pop is high, holding the back end; the two-entry job
//   queue takes jobs meanwhile until it fills, then full rises.
// reset:
//   synchronous rst empties the queue and result register, clears the glyph
//   rows and column count and marks the text as ended.
// stalls:
//   with pop low the result holds, the back end stops, the job queue fills
//   and full rises; no item or result is dropped.
`timescale 1ns / 1ps

module led_cube_text_scroller (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  lcts_pkg::item_t   item,
  input  logic              pop,
  output logic              empty,
  output lcts_pkg::result_t result
);

  // classified jobs from front to back
  lcts_pkg::job_t new_job;
  lcts_pkg::job_t head_job;
  logic           job_push;
  logic           job_pop;
  logic           job_empty;

  // front end: glyph rows, column count, end-of-text flag
  lcts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (job_push),
    .job      (new_job)
  );

  // decoupling queue, full here is the input side's full
  lcts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (new_job),
    .pop      (job_pop),
    .head     (head_job),
    .full     (full),
    .empty    (job_empty)
  );

  // back end: row counter and result register
  lcts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

>>> rtl/core/lcts_checker.sv
// port-level checks of the led cube text scroller and their bind
`timescale 1ns / 1ps

module lcts_checker (
  input logic              clk,
  input logic              rst,
  input logic              pop,
  input logic              empty,
  input lcts_pkg::result_t result
);

  // a status result is a single result with no write fields
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.write_valid |->
      result.last && result.write_mask == 8'h00 && result.write_data == 8'h00 &&
      result.frame_address == 6'd0 && !result.need_char)
    else $error("status result malformed");

  // written bits always lie inside the mask
  a_data_in_mask: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.write_data & ~result.write_mask) == 8'h00)
    else $error("write data outside mask");

  // a character request only comes with the final result of an item
  a_need_on_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.need_char |-> result.last)
    else $error("need_char before last");

  // a result that is not taken stays put
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("stalled result changed");

endmodule

bind led_cube_text_scroller lcts_checker u_checker (.*);

>>> tb/tb_led_cube_text_scroller.sv
// testbench of the led cube text scroller: queue-driven items, predicted and checked results
`timescale 1ns / 1ps

module tb_led_cube_text_scroller;

  // the one command code the package leaves unnamed, it must do nothing
  localparam logic [1:0] CMD_IDLE_CODE = 2'd3;
  localparam logic [6:0] TEXT_END = 7'h00;
  localparam logic [6:0] FIRST_PRINTABLE = 7'h20;
  localparam logic [2:0] COLUMNS_PER_GLYPH = 3'd6;
  localparam int RANDOM_ITEMS = 290;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  // 5x5 font for codes 0x20..0x7f, one byte per row, row 0 in the top byte
  localparam logic [39:0] GLYPH_TABLE [96] = '{
    40'h0000000000, 40'h0404040004, 40'h0A0A000000, 40'h0A1F0A1F0A,
    40'h0F140E051E, 40'h1102040811, 40'h08140D120D, 40'h0404000000,
    40'h0204040402, 40'h0804040408, 40'h150E1F0E15, 40'h04041F0404,
    40'h0000000408, 40'h00001F0000, 40'h0000000008, 40'h0102040810,
    40'h0E1315190E, 40'h040C04040E, 40'h0E11020C1F, 40'h0E1106110E,
    40'h040C1E0404, 40'h1E101E011E, 40'h0E101E110E, 40'h1F02040810,
    40'h0E110E110E, 40'h0E110E010E, 40'h0404000404, 40'h0404000408,
    40'h0408100804, 40'h001F001F00, 40'h0402010204, 40'h0E11060004,
    40'h0E1315170D, 40'h040A1F1111, 40'h1E111E111E, 40'h0E1110110E,
    40'h1E1111111E, 40'h1F101C101F, 40'h1F101C1010, 40'h0E1017120E,
    40'h11111F1111, 40'h0E0404040E, 40'h010101110E, 40'h11121C1211,
    40'h101010101F, 40'h111B151111, 40'h1119151311, 40'h0E1111110E,
    40'h1E111E1010, 40'h0E1115130F, 40'h1E111E1211, 40'h0F100E011E,
    40'h1F04040404, 40'h111111110E, 40'h1111110A04, 40'h111111150A,
    40'h110A040A11, 40'h110A040404, 40'h1F0204081F, 40'h0E0808080E,
    40'h1008040201, 40'h0E0202020E, 40'h040A110000, 40'h000000001F,
    40'h1010000000, 40'h040A1F1111, 40'h1E111E111E, 40'h0E1110110E,
    40'h1E1111111E, 40'h1F101C101F, 40'h1F101C1010, 40'h0E1017120E,
    40'h11111F1111, 40'h0E0404040E, 40'h010101110E, 40'h11121C1211,
    40'h101010101F, 40'h111B151111, 40'h1119151311, 40'h0E1111110E,
    40'h1E111E1010, 40'h0E1115130F, 40'h1E111E1211, 40'h0F100E011E,
    40'h1F04040404, 40'h111111110E, 40'h1111110A04, 40'h111111150A,
    40'h110A040A11, 40'h110A040404, 40'h1F0204081F, 40'h0608180806,
    40'h0404040404, 40'h0C0203020C, 40'h140A000000, 40'h1F1111111F
  };

  // one queued item, drain asks the sender to wait until all results are back
  typedef struct packed {
    lcts_pkg::item_t it;
    logic            drain;
  } cmd_entry_t;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  lcts_pkg::item_t   item;
  logic              pop;
  logic              empty;
  lcts_pkg::result_t result;

  cmd_entry_t        cmd_backlog[$];
  lcts_pkg::result_t owed_writes[$];

  // scroller state as the checker sees it
  logic [7:0] shadow_rows [5];
  logic [2:0] shadow_columns;
  logic       shadow_ended;

  cmd_entry_t cur_cmd;
  logic       busy;
  logic       taken;
  int         send_gap;
  int         pop_gap;
  logic       calm;
  int         mismatches;
  int         cycles;

  led_cube_text_scroller i_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .pop   (pop),
    .empty (empty),
    .result(result)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // mostly back to back or short gaps, now and then a long one; none at all while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) begin
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic add_cmd(input logic [1:0] cmd, input logic [6:0] code, input logic [2:0] x,
                         input logic [2:0] y, input logic [2:0] z, input logic drain);
    cmd_entry_t e;
    e.it.command   = lcts_pkg::command_t'(cmd);
    e.it.char_code = code;
    e.it.pos_x     = x;
    e.it.pos_y     = y;
    e.it.pos_z     = z;
    e.drain        = drain;
    cmd_backlog.push_back(e);
  endtask

  // works out the frame writes or status that one accepted item must give
  task automatic scroll_predict(input lcts_pkg::item_t it);
    lcts_pkg::result_t r;
    logic [7:0] m;
    logic [5:0] base;
    logic [6:0] idx;
    logic [39:0] glyph;
    int         sh;
    r = '0;
    case (it.command)
      lcts_pkg::CMD_LOAD: begin
        if (it.char_code == TEXT_END) begin
          // rows and column count survive the end of the text
          shadow_ended = 1'b1;
        end else begin
          // control codes show as space
          idx = (it.char_code < FIRST_PRINTABLE) ? 7'd0 : it.char_code - FIRST_PRINTABLE;
          glyph = GLYPH_TABLE[idx];
          for (int k = 0; k < 5; k++) begin
            shadow_rows[k] = glyph[39 - 8 * k -: 8];
          end
          shadow_columns = COLUMNS_PER_GLYPH;
          shadow_ended = 1'b0;
        end
        r.text_done = shadow_ended;
        r.last = 1'b1;
        owed_writes.push_back(r);
      end
      lcts_pkg::CMD_VERT: begin
        if (shadow_ended) begin
          // nothing drawn after the end, state untouched
          r.text_done = 1'b1;
          r.last = 1'b1;
          owed_writes.push_back(r);
        end else begin
          m = 8'h80 >> it.pos_x;
          base = {1'b0, it.pos_y[1:0], it.pos_z};
          for (int k = 0; k < 5; k++) begin
            r = '0;
            r.write_valid = 1'b1;
            r.frame_address = base + 6'(8 * k);
            r.write_mask = m;
            r.write_data = shadow_rows[k][5] ? m : 8'h00;
            shadow_rows[k] = shadow_rows[k] << 1;
            if (k == 4) begin
              // column count sticks at zero
              if (shadow_columns != 3'd0) begin
                shadow_columns = shadow_columns - 3'd1;
              end
              r.need_char = (shadow_columns == 3'd0);
              r.last = 1'b1;
            end
            owed_writes.push_back(r);
          end
        end
      end
      lcts_pkg::CMD_HORZ: begin
        // horizontal draw ignores the end of the text
        sh = 3 - it.pos_x[1:0];
        m = 8'h1F << sh;
        r.write_valid = 1'b1;
        r.frame_address = {it.pos_y, it.pos_z};
        r.write_mask = m;
        r.write_data = (shadow_rows[0] << sh) & m;
        for (int k = 0; k < 4; k++) begin
          shadow_rows[k] = shadow_rows[k + 1];
        end
        shadow_rows[4] = 8'h00;
        if (shadow_columns != 3'd0) begin
          shadow_columns = shadow_columns - 3'd1;
        end
        r.need_char = (shadow_columns == 3'd0) && !shadow_ended;
        r.text_done = shadow_ended;
        r.last = 1'b1;
        owed_writes.push_back(r);
      end
      default: begin
        r.text_done = shadow_ended;
        r.last = 1'b1;
        owed_writes.push_back(r);
      end
    endcase
  endtask

  // acceptance of an item: predict its results at the edge that takes it
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      scroll_predict(item);
      taken = 1'b1;
    end
  end

  // sender: one item in flight, random gaps between items
  always @(negedge clk) begin
    if (!rst) begin
      if (taken) begin
        taken = 1'b0;
        busy = 1'b0;
        send_gap = pick_gap();
        // switch between calm stretches and gappy ones now and then
        if ($urandom_range(0, 39) == 0) begin
          calm = !calm;
        end
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (cmd_backlog.size() > 0) begin
          // a drain item holds back until every owed result has come out
          if (!cmd_backlog[0].drain || owed_writes.size() == 0) begin
            cur_cmd = cmd_backlog.pop_front();
            busy = 1'b1;
          end
        end
      end
      push <= busy;
      if (busy) begin
        item <= cur_cmd.it;
      end
    end
  end

  // receiver: random stalls on pop
  always @(negedge clk) begin
    if (!rst) begin
      if (pop_gap > 0) begin
        pop_gap = pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_gap = pick_gap();
      end
    end
  end

  // checker: every accepted result against the oldest owed one
  always @(posedge clk) begin
    lcts_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (owed_writes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        mismatches = mismatches + 1;
      end else begin
        want = owed_writes.pop_front();
        if (result.write_valid !== want.write_valid ||
            result.frame_address !== want.frame_address ||
            result.write_mask !== want.write_mask ||
            result.write_data !== want.write_data ||
            result.need_char !== want.need_char ||
            result.text_done !== want.text_done ||
            result.last !== want.last) begin
          $display("%0t: mismatch expected v=%b a=%h m=%h d=%h need=%b done=%b last=%b",
                   $time, want.write_valid, want.frame_address, want.write_mask,
                   want.write_data, want.need_char, want.text_done, want.last);
          $display("%0t:          actual v=%b a=%h m=%h d=%h need=%b done=%b last=%b",
                   $time, result.write_valid, result.frame_address, result.write_mask,
                   result.write_data, result.need_char, result.text_done, result.last);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int         n_random;
    int         n_draws;
    logic [1:0] c;
    logic [6:0] code;
    int         r;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    item = '0;
    for (int k = 0; k < 5; k++) begin
      shadow_rows[k] = 8'h00;
    end
    shadow_columns = 3'd0;
    shadow_ended = 1'b1;
    busy = 1'b0;
    taken = 1'b0;
    send_gap = 0;
    pop_gap = 0;
    calm = 1'b0;
    mismatches = 0;
    cycles = 0;

    // directed: draws before any text, unused command
    add_cmd(lcts_pkg::CMD_VERT, 7'h7F, 3'd7, 3'd7, 3'd7, 1'b0);
    add_cmd(lcts_pkg::CMD_HORZ, 7'h00, 3'd0, 3'd7, 3'd7, 1'b0);
    add_cmd(CMD_IDLE_CODE, 7'h00, 3'd0, 3'd0, 3'd0, 1'b0);
    // one glyph drawn column by column until it runs out, then past the end
    add_cmd(lcts_pkg::CMD_LOAD, 7'h41, 3'd0, 3'd0, 3'd0, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd0, 3'd0, 3'd0, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd7, 3'd7, 3'd7, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd3, 3'd4, 3'd5, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd1, 3'd2, 3'd6, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd6, 3'd1, 3'd2, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd4, 3'd3, 3'd0, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd5, 3'd6, 3'd1, 1'b0);
    add_cmd(lcts_pkg::CMD_HORZ, 7'h00, 3'd2, 3'd5, 3'd4, 1'b0);
    // control code shows as space; sender drains first
    add_cmd(lcts_pkg::CMD_LOAD, 7'h01, 3'd0, 3'd0, 3'd0, 1'b1);
    add_cmd(lcts_pkg::CMD_LOAD, 7'h7F, 3'd7, 3'd7, 3'd7, 1'b0);
    add_cmd(lcts_pkg::CMD_HORZ, 7'h00, 3'd0, 3'd0, 3'd0, 1'b0);
    add_cmd(lcts_pkg::CMD_HORZ, 7'h00, 3'd1, 3'd7, 3'd7, 1'b0);
    add_cmd(lcts_pkg::CMD_HORZ, 7'h00, 3'd2, 3'd3, 3'd1, 1'b0);
    add_cmd(lcts_pkg::CMD_LOAD, 7'h23, 3'd0, 3'd0, 3'd0, 1'b0);
    add_cmd(lcts_pkg::CMD_HORZ, 7'h00, 3'd3, 3'd1, 3'd6, 1'b0);
    add_cmd(lcts_pkg::CMD_HORZ, 7'h00, 3'd7, 3'd6, 3'd3, 1'b0);
    add_cmd(lcts_pkg::CMD_LOAD, FIRST_PRINTABLE, 3'd0, 3'd0, 3'd0, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd2, 3'd7, 3'd7, 1'b0);
    // end of text, then draws after it
    add_cmd(lcts_pkg::CMD_LOAD, TEXT_END, 3'd7, 3'd7, 3'd7, 1'b0);
    add_cmd(lcts_pkg::CMD_VERT, 7'h00, 3'd0, 3'd0, 3'd0, 1'b0);
    add_cmd(lcts_pkg::CMD_HORZ, 7'h7F, 3'd3, 3'd7, 3'd7, 1'b0);

    // random: mostly a load followed by a run of draws, some noise between
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        if ($urandom_range(0, 7) == 0) begin
          code = 7'($urandom_range(0, 127));
        end else begin
          code = 7'($urandom_range(33, 126));
        end
        add_cmd(lcts_pkg::CMD_LOAD, code, 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                ($urandom_range(0, 24) == 0));
        n_random = n_random + 1;
        n_draws = $urandom_range(3, 9);
        for (int d = 0; d < n_draws; d++) begin
          r = $urandom_range(0, 99);
          c = (r < 60) ? lcts_pkg::CMD_VERT : (r < 95) ? lcts_pkg::CMD_HORZ : CMD_IDLE_CODE;
          add_cmd(c, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 1'b0);
          n_random = n_random + 1;
        end
      end else begin
        n_draws = $urandom_range(1, 4);
        for (int d = 0; d < n_draws; d++) begin
          add_cmd(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), 1'b0);
          n_random = n_random + 1;
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() > 0 || busy) begin
      @(posedge clk);
    end
    while (owed_writes.size() > 0) begin
      @(posedge clk);
    end
    // let any stray result show up
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lcts_pkg.sv
rtl/core/lcts_front.sv
rtl/core/lcts_queue.sv
rtl/core/lcts_back.sv
rtl/core/led_cube_text_scroller.sv
rtl/core/lcts_checker.sv
tb/tb_led_cube_text_scroller.sv
